[sv/assert_macros.svh]
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, skipped while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset cycles included
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tsp_pkg.sv]
// Types and constants of the transaction stream parser
package tsp_pkg;

  // Input request: one transaction byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
  } in_t;

  // Result request: the tag of one byte
  typedef struct packed {
    logic [3:0]  field_kind;
    logic [15:0] item_index;
    logic [4:0]  byte_offset;
    logic [63:0] field_value;
    logic        field_done;
    logic        tx_done;
    logic [1:0]  error_code;
  } out_t;

  // Field kinds
  localparam logic [3:0] KIND_VERSION     = 4'd0;
  localparam logic [3:0] KIND_IN_COUNT    = 4'd1;
  localparam logic [3:0] KIND_PREV_HASH   = 4'd2;
  localparam logic [3:0] KIND_PREV_INDEX  = 4'd3;
  localparam logic [3:0] KIND_SIG_LEN     = 4'd4;
  localparam logic [3:0] KIND_SIG_BYTE    = 4'd5;
  localparam logic [3:0] KIND_SEQUENCE    = 4'd6;
  localparam logic [3:0] KIND_OUT_COUNT   = 4'd7;
  localparam logic [3:0] KIND_AMOUNT      = 4'd8;
  localparam logic [3:0] KIND_PUBKEY_LEN  = 4'd9;
  localparam logic [3:0] KIND_PUBKEY_BYTE = 4'd10;
  localparam logic [3:0] KIND_LOCKTIME    = 4'd11;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_COUNT  = 2'd1;
  localparam logic [1:0] ERR_SCRIPT = 2'd2;
  localparam logic [1:0] ERR_IDLE   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MAX_ITEM_COUNT    = 1'b0;
  localparam logic CFG_MAX_SCRIPT_LENGTH = 1'b1;

  // Configuration reset values
  localparam logic [15:0] MAX_ITEM_COUNT_RST    = 16'd4096;
  localparam logic [15:0] MAX_SCRIPT_LENGTH_RST = 16'd10000;

  // Varint prefixes
  localparam logic [7:0] VARINT_P16 = 8'hfd;
  localparam logic [7:0] VARINT_P32 = 8'hfe;

  // Parse phases
  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0_0000_0000_0001,
    PH_VER    = 13'b0_0000_0000_0010,
    PH_INCNT  = 13'b0_0000_0000_0100,
    PH_HASH   = 13'b0_0000_0000_1000,
    PH_PIDX   = 13'b0_0000_0001_0000,
    PH_SIGLEN = 13'b0_0000_0010_0000,
    PH_SIG    = 13'b0_0000_0100_0000,
    PH_SEQ    = 13'b0_0000_1000_0000,
    PH_OUTCNT = 13'b0_0001_0000_0000,
    PH_AMT    = 13'b0_0010_0000_0000,
    PH_PKLEN  = 13'b0_0100_0000_0000,
    PH_PK     = 13'b0_1000_0000_0000,
    PH_LOCK   = 13'b1_0000_0000_0000
  } phase_t;

endpackage

[sv/transaction_stream_parser_unit.sv]
// Top level of the transaction stream parser
//
// Takes a legacy transaction one byte per input request (in_valid/in_stall,
// in_payload) and returns one tag per byte on the result channel
// (out_valid/out_stall, out_payload): field kind, input or output number,
// offset within the field, value assembled so far, field and transaction
// completion flags and an error code.
// The tag of a byte is registered and shown in the cycle after the byte is
// taken. One byte per cycle unless the receiver stalls; parse state, counters
// and the result register all update in the cycle that accepts the byte.
// A result register parts the two channels: a new byte is taken whenever the
// register is empty or its content is taken in the same cycle. While the
// receiver stalls a held result, in_stall is high and the result holds.
// The user writes the limits on counts and script lengths through cfg_we,
// cfg_index and cfg_wdata while no byte is in flight; it is not enforced.
// Synchronous reset (rst_n low) empties the result register, returns the
// parser to idle and loads the default limits (4096 items, 10000 script
// bytes). A byte flagged start_flag begins a new transaction at any time.
module transaction_stream_parser_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tsp_pkg::in_t     in_payload,
  output logic             out_valid,
  input  logic             out_stall,
  output tsp_pkg::out_t    out_payload,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wdata
);

  // Configuration
  logic [15:0] max_item_r;
  logic [15:0] max_script_r;

  // Parse state
  tsp_pkg::phase_t ph_r, ph_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vleft_r, vleft_nxt;
  logic [15:0] ins_r, ins_nxt;
  logic [15:0] outs_r, outs_nxt;
  logic [15:0] item_r, item_nxt;
  logic [15:0] sleft_r, sleft_nxt;

  // Result register
  logic          out_valid_r;
  tsp_pkg::out_t out_payload_r;
  tsp_pkg::out_t res;

  logic in_accept;

  // State as seen by this byte once a start has been applied
  tsp_pkg::phase_t ph_e;
  logic [5:0]  pos_e;
  logic [63:0] acc_e;
  logic [3:0]  vleft_e;
  logic [15:0] ins_e, outs_e, item_e, sleft_e;

  // Working values
  logic [63:0] byte_word;
  logic [63:0] acc_upd;
  logic [3:0]  vleft_upd;
  logic [15:0] sleft_dec;
  logic [15:0] cnt_dec;
  logic [5:0]  pos_m1;
  logic        fin;
  logic        enter;
  logic        over_cnt;
  logic        over_script;
  logic        val_zero;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  // Apply start before the byte is parsed
  always_comb begin
    if (in_payload.start_flag) begin
      ph_e    = tsp_pkg::PH_VER;
      pos_e   = '0;
      acc_e   = '0;
      vleft_e = '0;
      ins_e   = '0;
      outs_e  = '0;
      item_e  = '0;
      sleft_e = '0;
    end else begin
      ph_e    = ph_r;
      pos_e   = pos_r;
      acc_e   = acc_r;
      vleft_e = vleft_r;
      ins_e   = ins_r;
      outs_e  = outs_r;
      item_e  = item_r;
      sleft_e = sleft_r;
    end
  end

  // Parse one byte: tag it and work out the next state
  always_comb begin
    byte_word   = {56'd0, in_payload.data_byte};
    pos_m1      = pos_e - 6'd1;
    acc_upd     = acc_e;
    vleft_upd   = vleft_e;
    sleft_dec   = sleft_e - {15'd0, (sleft_e != 16'd0)};
    fin         = 1'b0;
    enter       = 1'b0;
    res         = '0;
    ph_nxt      = ph_e;
    pos_nxt     = pos_e + 6'd1;
    ins_nxt     = ins_e;
    outs_nxt    = outs_e;
    item_nxt    = item_e;
    sleft_nxt   = sleft_e;
    cnt_dec     = '0;

    // Field kind and item number of this byte
    case (ph_e)
      tsp_pkg::PH_VER:    res.field_kind = tsp_pkg::KIND_VERSION;
      tsp_pkg::PH_INCNT:  res.field_kind = tsp_pkg::KIND_IN_COUNT;
      tsp_pkg::PH_HASH:   res.field_kind = tsp_pkg::KIND_PREV_HASH;
      tsp_pkg::PH_PIDX:   res.field_kind = tsp_pkg::KIND_PREV_INDEX;
      tsp_pkg::PH_SIGLEN: res.field_kind = tsp_pkg::KIND_SIG_LEN;
      tsp_pkg::PH_SIG:    res.field_kind = tsp_pkg::KIND_SIG_BYTE;
      tsp_pkg::PH_SEQ:    res.field_kind = tsp_pkg::KIND_SEQUENCE;
      tsp_pkg::PH_OUTCNT: res.field_kind = tsp_pkg::KIND_OUT_COUNT;
      tsp_pkg::PH_AMT:    res.field_kind = tsp_pkg::KIND_AMOUNT;
      tsp_pkg::PH_PKLEN:  res.field_kind = tsp_pkg::KIND_PUBKEY_LEN;
      tsp_pkg::PH_PK:     res.field_kind = tsp_pkg::KIND_PUBKEY_BYTE;
      tsp_pkg::PH_LOCK:   res.field_kind = tsp_pkg::KIND_LOCKTIME;
      default:            res.field_kind = tsp_pkg::KIND_VERSION;
    endcase
    if (ph_e inside {tsp_pkg::PH_HASH, tsp_pkg::PH_PIDX, tsp_pkg::PH_SIGLEN,
                     tsp_pkg::PH_SIG, tsp_pkg::PH_SEQ, tsp_pkg::PH_AMT,
                     tsp_pkg::PH_PKLEN, tsp_pkg::PH_PK}) begin
      res.item_index = item_e;
    end
    res.byte_offset = pos_e[4:0];

    // Assemble the field value
    case (ph_e)
      tsp_pkg::PH_VER, tsp_pkg::PH_PIDX, tsp_pkg::PH_SEQ, tsp_pkg::PH_LOCK: begin
        acc_upd         = acc_e | (byte_word << {pos_e[2:0], 3'b000});
        fin             = (pos_e >= 6'd3);
        res.field_value = acc_upd;
      end
      tsp_pkg::PH_AMT: begin
        acc_upd         = acc_e | (byte_word << {pos_e[2:0], 3'b000});
        fin             = (pos_e >= 6'd7);
        res.field_value = acc_upd;
      end
      tsp_pkg::PH_HASH: begin
        fin             = (pos_e >= 6'd31);
        res.field_value = byte_word;
      end
      tsp_pkg::PH_SIG, tsp_pkg::PH_PK: begin
        sleft_nxt       = sleft_dec;
        fin             = (sleft_dec == 16'd0);
        res.field_value = byte_word;
      end
      tsp_pkg::PH_INCNT, tsp_pkg::PH_SIGLEN, tsp_pkg::PH_OUTCNT,
      tsp_pkg::PH_PKLEN: begin
        if (pos_e == 6'd0) begin
          if (in_payload.data_byte < tsp_pkg::VARINT_P16) begin
            acc_upd = byte_word;
            fin     = 1'b1;
          end else begin
            acc_upd = '0;
            if (in_payload.data_byte == tsp_pkg::VARINT_P16) begin
              vleft_upd = 4'd2;
            end else if (in_payload.data_byte == tsp_pkg::VARINT_P32) begin
              vleft_upd = 4'd4;
            end else begin
              vleft_upd = 4'd8;
            end
          end
        end else begin
          acc_upd   = acc_e | (byte_word << {pos_m1[2:0], 3'b000});
          vleft_upd = vleft_e - {3'd0, (vleft_e != 4'd0)};
          fin       = (vleft_upd == 4'd0);
        end
        res.field_value = acc_upd;
      end
      default: ;
    endcase

    over_cnt    = (|acc_upd[63:16]) || (acc_upd[15:0] > max_item_r);
    over_script = (|acc_upd[63:16]) || (acc_upd[15:0] > max_script_r);
    val_zero    = (acc_upd[15:0] == 16'd0);
    res.field_done = fin;

    // Advance when the field completes; errors and locktime return to idle
    if (fin) begin
      enter = 1'b1;
      case (ph_e)
        tsp_pkg::PH_VER: ph_nxt = tsp_pkg::PH_INCNT;
        tsp_pkg::PH_INCNT: begin
          if (over_cnt) begin
            res.error_code = tsp_pkg::ERR_COUNT;
            ph_nxt         = tsp_pkg::PH_IDLE;
          end else begin
            ins_nxt  = acc_upd[15:0];
            item_nxt = '0;
            ph_nxt   = val_zero ? tsp_pkg::PH_OUTCNT : tsp_pkg::PH_HASH;
          end
        end
        tsp_pkg::PH_HASH: ph_nxt = tsp_pkg::PH_PIDX;
        tsp_pkg::PH_PIDX: ph_nxt = tsp_pkg::PH_SIGLEN;
        tsp_pkg::PH_SIGLEN: begin
          if (over_script) begin
            res.error_code = tsp_pkg::ERR_SCRIPT;
            ph_nxt         = tsp_pkg::PH_IDLE;
          end else begin
            sleft_nxt = acc_upd[15:0];
            ph_nxt    = val_zero ? tsp_pkg::PH_SEQ : tsp_pkg::PH_SIG;
          end
        end
        tsp_pkg::PH_SIG: ph_nxt = tsp_pkg::PH_SEQ;
        tsp_pkg::PH_SEQ: begin
          cnt_dec = ins_e - {15'd0, (ins_e != 16'd0)};
          ins_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            item_nxt = '0;
            ph_nxt   = tsp_pkg::PH_OUTCNT;
          end else begin
            item_nxt = item_e + 16'd1;
            ph_nxt   = tsp_pkg::PH_HASH;
          end
        end
        tsp_pkg::PH_OUTCNT: begin
          if (over_cnt) begin
            res.error_code = tsp_pkg::ERR_COUNT;
            ph_nxt         = tsp_pkg::PH_IDLE;
          end else begin
            outs_nxt = acc_upd[15:0];
            item_nxt = '0;
            ph_nxt   = val_zero ? tsp_pkg::PH_LOCK : tsp_pkg::PH_AMT;
          end
        end
        tsp_pkg::PH_AMT: ph_nxt = tsp_pkg::PH_PKLEN;
        tsp_pkg::PH_PKLEN, tsp_pkg::PH_PK: begin
          if ((ph_e == tsp_pkg::PH_PKLEN) && over_script) begin
            res.error_code = tsp_pkg::ERR_SCRIPT;
            ph_nxt         = tsp_pkg::PH_IDLE;
          end else begin
            if (ph_e == tsp_pkg::PH_PKLEN) begin
              sleft_nxt = acc_upd[15:0];
            end
            if ((ph_e == tsp_pkg::PH_PKLEN) && !val_zero) begin
              ph_nxt = tsp_pkg::PH_PK;
            end else begin
              // Close this output
              cnt_dec  = outs_e - {15'd0, (outs_e != 16'd0)};
              outs_nxt = cnt_dec;
              if (cnt_dec == 16'd0) begin
                item_nxt = '0;
                ph_nxt   = tsp_pkg::PH_LOCK;
              end else begin
                item_nxt = item_e + 16'd1;
                ph_nxt   = tsp_pkg::PH_AMT;
              end
            end
          end
        end
        tsp_pkg::PH_LOCK: begin
          res.tx_done = 1'b1;
          ph_nxt      = tsp_pkg::PH_IDLE;
        end
        default: ph_nxt = tsp_pkg::PH_IDLE;
      endcase
    end

    // A byte while idle without start: flag it and stay idle
    if (ph_e == tsp_pkg::PH_IDLE) begin
      res            = '0;
      res.error_code = tsp_pkg::ERR_IDLE;
      ph_nxt         = tsp_pkg::PH_IDLE;
      enter          = 1'b1;
    end

    // Entering a field clears its byte position and value
    if (enter) begin
      pos_nxt   = '0;
      acc_nxt   = '0;
      vleft_nxt = '0;
    end else begin
      acc_nxt   = acc_upd;
      vleft_nxt = vleft_upd;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_item_r   <= tsp_pkg::MAX_ITEM_COUNT_RST;
      max_script_r <= tsp_pkg::MAX_SCRIPT_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsp_pkg::CFG_MAX_ITEM_COUNT:    max_item_r   <= cfg_wdata;
        tsp_pkg::CFG_MAX_SCRIPT_LENGTH: max_script_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parse state: advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= tsp_pkg::PH_IDLE;
      pos_r   <= '0;
      acc_r   <= '0;
      vleft_r <= '0;
      ins_r   <= '0;
      outs_r  <= '0;
      item_r  <= '0;
      sleft_r <= '0;
    end else if (in_accept) begin
      ph_r    <= ph_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      vleft_r <= vleft_nxt;
      ins_r   <= ins_nxt;
      outs_r  <= outs_nxt;
      item_r  <= item_nxt;
      sleft_r <= sleft_nxt;
    end
  end

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_payload_r <= res;
    end
  end

endmodule

[sv/tsp_checker.sv]
// Port-level checker for the transaction stream parser, bound to the top level
`include "assert_macros.svh"

module tsp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input tsp_pkg::out_t out_payload
);

  // Reset empties the result register
  `ASSERT_CLK_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // Input stalls only behind a held result
  `ASSERT_CLK(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled without a held result")

  // A stalled result holds
  `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_payload)), "stalled result changed")

  // End of transaction only on the completing locktime byte
  `ASSERT_CLK(a_tx_done, clk, rst_n, (out_valid && out_payload.tx_done) |-> (out_payload.field_done && (out_payload.field_kind == tsp_pkg::KIND_LOCKTIME) && (out_payload.error_code == tsp_pkg::ERR_NONE)), "tx_done on a byte that is not the last locktime byte")

  // An idle byte carries nothing but its error code
  `ASSERT_CLK(a_idle_err, clk, rst_n, (out_valid && (out_payload.error_code == tsp_pkg::ERR_IDLE)) |-> ((out_payload.field_value == 64'd0) && !out_payload.field_done && (out_payload.item_index == 16'd0)), "idle error result carries field data")

endmodule

bind transaction_stream_parser_unit tsp_checker u_tsp_checker (.*);

[test/transaction_stream_parser_unit_tb.sv]
// Self-checking testbench for the transaction stream parser unit
`timescale 1ns / 1ps

module transaction_stream_parser_unit_tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int END_CYCLES   = 4;
  localparam logic [7:0] VARINT_P64 = 8'hff;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_valid   = 1'b0;
  logic          in_stall;
  tsp_pkg::in_t  in_payload = '0;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  tsp_pkg::out_t out_payload;
  logic          cfg_we     = 1'b0;
  logic          cfg_index  = 1'b0;
  logic [15:0]   cfg_wdata  = '0;

  // Idling percentages of both sides and the long receiver hold-off
  int send_idle_pct = 24;
  int recv_idle_pct = 77;
  int hold_request  = 0;
  int hold_seen     = 0;
  int hold_run      = 0;

  int fail_count  = 0;
  int cycle_count = 0;

  // Parser state as predicted by the testbench
  tsp_pkg::phase_t prs_phase;
  logic [5:0]      prs_pos;
  logic [63:0]     prs_acc;
  logic [3:0]      prs_varint_left;
  logic [15:0]     prs_inputs_left;
  logic [15:0]     prs_outputs_left;
  logic [15:0]     prs_item;
  logic [15:0]     prs_script_left;
  logic [15:0]     lim_items;
  logic [15:0]     lim_script;

  // Tags expected from the block, oldest first
  tsp_pkg::out_t tag_queue[$];
  // Bytes of the transaction being built
  logic [7:0] tx_bytes[$];

  always #(CLK_HALF) clk = ~clk;

  transaction_stream_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Enter a phase with a fresh field
  function automatic void move_to(tsp_pkg::phase_t p);
    prs_phase       = p;
    prs_pos         = '0;
    prs_acc         = '0;
    prs_varint_left = '0;
  endfunction

  // Advance to the next output, or to locktime after the last one
  function automatic void close_output();
    if (prs_outputs_left != 0) prs_outputs_left = prs_outputs_left - 16'd1;
    prs_item = prs_item + 16'd1;
    if (prs_outputs_left == 0) begin
      prs_item = '0;
      move_to(tsp_pkg::PH_LOCK);
    end else begin
      move_to(tsp_pkg::PH_AMT);
    end
  endfunction

  // Work out the tag of one byte and advance the predicted parser
  function automatic tsp_pkg::out_t predict_tag(logic [7:0] b, logic first);
    tsp_pkg::out_t   t;
    tsp_pkg::phase_t ph;
    logic            fin;
    logic [63:0]     v;
    logic [2:0]      slot;
    t   = '0;
    fin = 1'b0;
    if (first) begin
      move_to(tsp_pkg::PH_VER);
      prs_inputs_left  = '0;
      prs_outputs_left = '0;
      prs_item         = '0;
      prs_script_left  = '0;
    end
    ph = prs_phase;
    if (ph == tsp_pkg::PH_IDLE) begin
      move_to(tsp_pkg::PH_IDLE);
      t.error_code = tsp_pkg::ERR_IDLE;
      return t;
    end

    // Tag the byte with its field and, inside an input or output, its number
    case (ph)
      tsp_pkg::PH_VER:    t.field_kind = tsp_pkg::KIND_VERSION;
      tsp_pkg::PH_INCNT:  t.field_kind = tsp_pkg::KIND_IN_COUNT;
      tsp_pkg::PH_OUTCNT: t.field_kind = tsp_pkg::KIND_OUT_COUNT;
      tsp_pkg::PH_LOCK:   t.field_kind = tsp_pkg::KIND_LOCKTIME;
      tsp_pkg::PH_HASH: begin
        t.field_kind = tsp_pkg::KIND_PREV_HASH;
        t.item_index = prs_item;
      end
      tsp_pkg::PH_PIDX: begin
        t.field_kind = tsp_pkg::KIND_PREV_INDEX;
        t.item_index = prs_item;
      end
      tsp_pkg::PH_SIGLEN: begin
        t.field_kind = tsp_pkg::KIND_SIG_LEN;
        t.item_index = prs_item;
      end
      tsp_pkg::PH_SIG: begin
        t.field_kind = tsp_pkg::KIND_SIG_BYTE;
        t.item_index = prs_item;
      end
      tsp_pkg::PH_SEQ: begin
        t.field_kind = tsp_pkg::KIND_SEQUENCE;
        t.item_index = prs_item;
      end
      tsp_pkg::PH_AMT: begin
        t.field_kind = tsp_pkg::KIND_AMOUNT;
        t.item_index = prs_item;
      end
      tsp_pkg::PH_PKLEN: begin
        t.field_kind = tsp_pkg::KIND_PUBKEY_LEN;
        t.item_index = prs_item;
      end
      default: begin
        t.field_kind = tsp_pkg::KIND_PUBKEY_BYTE;
        t.item_index = prs_item;
      end
    endcase
    t.byte_offset = prs_pos[4:0];

    // Accumulate the field value
    case (ph)
      tsp_pkg::PH_VER, tsp_pkg::PH_PIDX, tsp_pkg::PH_SEQ, tsp_pkg::PH_LOCK,
      tsp_pkg::PH_AMT: begin
        prs_acc = prs_acc | ({56'b0, b} << {prs_pos[2:0], 3'b000});
        fin = (int'(prs_pos) + 1) >= ((ph == tsp_pkg::PH_AMT) ? 8 : 4);
        t.field_value = prs_acc;
      end
      tsp_pkg::PH_HASH: begin
        fin = prs_pos >= 6'd31;
        t.field_value = {56'b0, b};
      end
      tsp_pkg::PH_SIG, tsp_pkg::PH_PK: begin
        if (prs_script_left != 0) prs_script_left = prs_script_left - 16'd1;
        fin = prs_script_left == 0;
        t.field_value = {56'b0, b};
      end
      default: begin
        // varint: prefix at offset 0, little-endian bytes after it
        if (prs_pos == 0) begin
          if (b < tsp_pkg::VARINT_P16) begin
            prs_acc = {56'b0, b};
            fin = 1'b1;
          end else begin
            prs_varint_left = (b == tsp_pkg::VARINT_P16) ? 4'd2 :
                              (b == tsp_pkg::VARINT_P32) ? 4'd4 : 4'd8;
            prs_acc = '0;
          end
        end else begin
          slot = prs_pos[2:0] - 3'd1;
          prs_acc = prs_acc | ({56'b0, b} << {slot, 3'b000});
          if (prs_varint_left != 0) prs_varint_left = prs_varint_left - 4'd1;
          fin = prs_varint_left == 0;
        end
        t.field_value = prs_acc;
      end
    endcase

    prs_pos      = prs_pos + 6'd1;
    t.field_done = fin;
    if (!fin) return t;

    // Move on once the field is complete
    v = prs_acc;
    case (ph)
      tsp_pkg::PH_VER:  move_to(tsp_pkg::PH_INCNT);
      tsp_pkg::PH_HASH: move_to(tsp_pkg::PH_PIDX);
      tsp_pkg::PH_PIDX: move_to(tsp_pkg::PH_SIGLEN);
      tsp_pkg::PH_SIG:  move_to(tsp_pkg::PH_SEQ);
      tsp_pkg::PH_AMT:  move_to(tsp_pkg::PH_PKLEN);
      tsp_pkg::PH_PK:   close_output();
      tsp_pkg::PH_SEQ: begin
        if (prs_inputs_left != 0) prs_inputs_left = prs_inputs_left - 16'd1;
        prs_item = prs_item + 16'd1;
        if (prs_inputs_left == 0) begin
          prs_item = '0;
          move_to(tsp_pkg::PH_OUTCNT);
        end else begin
          move_to(tsp_pkg::PH_HASH);
        end
      end
      tsp_pkg::PH_INCNT, tsp_pkg::PH_OUTCNT: begin
        if (v > {48'b0, lim_items}) begin
          t.error_code = tsp_pkg::ERR_COUNT;
          move_to(tsp_pkg::PH_IDLE);
        end else begin
          prs_item = '0;
          if (ph == tsp_pkg::PH_INCNT) begin
            prs_inputs_left = v[15:0];
            if (v == 0) move_to(tsp_pkg::PH_OUTCNT);
            else move_to(tsp_pkg::PH_HASH);
          end else begin
            prs_outputs_left = v[15:0];
            if (v == 0) move_to(tsp_pkg::PH_LOCK);
            else move_to(tsp_pkg::PH_AMT);
          end
        end
      end
      tsp_pkg::PH_SIGLEN, tsp_pkg::PH_PKLEN: begin
        if (v > {48'b0, lim_script}) begin
          t.error_code = tsp_pkg::ERR_SCRIPT;
          move_to(tsp_pkg::PH_IDLE);
        end else begin
          prs_script_left = v[15:0];
          if (ph == tsp_pkg::PH_SIGLEN) begin
            if (v == 0) move_to(tsp_pkg::PH_SEQ);
            else move_to(tsp_pkg::PH_SIG);
          end else begin
            if (v == 0) close_output();
            else move_to(tsp_pkg::PH_PK);
          end
        end
      end
      default: begin
        t.tx_done = 1'b1;
        move_to(tsp_pkg::PH_IDLE);
      end
    endcase
    return t;
  endfunction

  // Append one byte to the transaction being built
  function automatic void add_byte(logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endfunction

  // Append random bytes to the transaction being built
  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
  endfunction

  // Append a varint, in its short form or with a prefix wide enough for the value
  function automatic void put_varint(logic [63:0] v);
    int         nb;
    logic [7:0] prefix;
    if (v < 64'hfd && $urandom_range(3) != 0) begin
      add_byte(v[7:0]);
      return;
    end
    nb = (v <= 64'hffff) ? 2 : (v <= 64'hffff_ffff) ? 4 : 8;
    if (nb == 2 && $urandom_range(3) == 0) nb = 4;
    if (nb == 4 && $urandom_range(3) == 0) nb = 8;
    prefix = (nb == 2) ? tsp_pkg::VARINT_P16 : (nb == 4) ? tsp_pkg::VARINT_P32 : VARINT_P64;
    add_byte(prefix);
    for (int i = 0; i < nb; i++) add_byte(v[8*i +: 8]);
  endfunction

  // Pick a count or length: mostly small and legal, now and then over the limit
  function automatic logic [63:0] pick_size(logic [15:0] limit, int span);
    int r;
    int hi;
    r  = $urandom_range(99);
    hi = (int'(limit) < span) ? int'(limit) : span;
    if (r < 2) return {48'b0, limit} + 64'd1;
    if (r < 4) return {$urandom, $urandom} | 64'h1_0000;
    if (r < 16 && int'(limit) <= span) return {48'b0, limit};
    return 64'($urandom_range(hi, 0));
  endfunction

  // Build one transaction under the current limits, cut short after an over-limit size
  function automatic void build_tx();
    logic [63:0] cnt;
    logic [63:0] len;
    tx_bytes.delete();
    put_random(4);
    cnt = pick_size(lim_items, 3);
    put_varint(cnt);
    if (cnt > {48'b0, lim_items}) return;
    for (int i = 0; i < int'(cnt); i++) begin
      put_random(36);
      len = pick_size(lim_script, ($urandom_range(9) == 0) ? 140 : 24);
      put_varint(len);
      if (len > {48'b0, lim_script}) return;
      put_random(int'(len));
      put_random(4);
    end
    cnt = pick_size(lim_items, 3);
    put_varint(cnt);
    if (cnt > {48'b0, lim_items}) return;
    for (int i = 0; i < int'(cnt); i++) begin
      put_random(8);
      len = pick_size(lim_script, ($urandom_range(9) == 0) ? 140 : 24);
      put_varint(len);
      if (len > {48'b0, lim_script}) return;
      put_random(int'(len));
    end
    put_random(4);
  endfunction

  // Offer one byte request, hold it until taken, then record its expected tag
  task automatic send_byte(input logic [7:0] data, input logic first);
    tsp_pkg::in_t req;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req.data_byte  = data;
    req.start_flag = first;
    in_payload <= req;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    tag_queue.insert(tag_queue.size(), predict_tag(data, first));
  endtask

  // Drop valid and wait for every outstanding tag
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tag_queue.size() != 0) @(posedge clk);
  endtask

  // Write both limit registers on consecutive cycles
  task automatic set_limits(input logic [15:0] items, input logic [15:0] script);
    cfg_we    <= 1'b1;
    cfg_index <= tsp_pkg::CFG_MAX_ITEM_COUNT;
    cfg_wdata <= items;
    @(posedge clk);
    cfg_index <= tsp_pkg::CFG_MAX_SCRIPT_LENGTH;
    cfg_wdata <= script;
    @(posedge clk);
    cfg_we     <= 1'b0;
    lim_items  = items;
    lim_script = script;
  endtask

  // Stream random transactions with truncations and stray bytes mixed in
  task automatic run_traffic(input int send_pct, input int recv_pct,
                             input logic [15:0] items, input logic [15:0] script,
                             input int budget);
    int sent;
    int cut;
    int stray;
    wait_idle();
    set_limits(items, script);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      build_tx();
      cut = tx_bytes.size();
      if (cut > 1 && $urandom_range(9) == 0) cut = $urandom_range(cut - 1, 1);
      for (int i = 0; i < cut; i++) send_byte(tx_bytes[i], i == 0);
      sent += cut;
      if ($urandom_range(9) == 0) begin
        stray = $urandom_range(3, 1);
        repeat (stray) send_byte(8'($urandom_range(255)), 1'b0);
        sent += stray;
      end
    end
  endtask

  // Directed bytes under the reset limits
  task automatic test_directed();
    // stray byte while idle
    send_byte(8'h00, 1'b0);
    // abandon a transaction after three version bytes
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    // shortest transaction: no inputs, no outputs
    send_byte(8'h7f, 1'b1);
    repeat (3) send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    // input count through an eight-byte varint, far over the limit
    send_byte(8'h02, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(VARINT_P64, 1'b0);
    repeat (8) send_byte(8'hff, 1'b0);
    // parser is idle again after the count error
    send_byte(tsp_pkg::VARINT_P16, 1'b0);
  endtask

  task automatic test_tight_limits();
    run_traffic(24, 77, 16'd1, 16'd0, 400);
  endtask

  task automatic test_wide_limits();
    run_traffic(77, 24, 16'hffff, 16'hffff, 440);
  endtask

  task automatic test_mid_limits();
    run_traffic(0, 0, 16'($urandom_range(5, 2)), 16'($urandom_range(80, 16)), 360);
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    wait_idle();
    hold_request++;
    run_traffic(0, 0, lim_items, lim_script, 60);
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_run  = HOLD_CYCLES;
    end
    if (hold_run != 0) begin
      hold_run  = hold_run - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted tag with the oldest expectation
  always @(posedge clk) begin : check_tags
    tsp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tag_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected tag: kind %0d item %0d offset %0d value %h err %0d",
                   out_payload.field_kind, out_payload.item_index,
                   out_payload.byte_offset, out_payload.field_value,
                   out_payload.error_code);
      end else begin
        want = tag_queue.pop_front();
        if (out_payload.field_kind  !== want.field_kind  ||
            out_payload.item_index  !== want.item_index  ||
            out_payload.byte_offset !== want.byte_offset ||
            out_payload.field_value !== want.field_value ||
            out_payload.field_done  !== want.field_done  ||
            out_payload.tx_done     !== want.tx_done     ||
            out_payload.error_code  !== want.error_code) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("tag mismatch");
            $display("  expected kind %0d item %0d offset %0d value %h done %b tx %b err %0d",
                     want.field_kind, want.item_index, want.byte_offset,
                     want.field_value, want.field_done, want.tx_done, want.error_code);
            $display("  actual   kind %0d item %0d offset %0d value %h done %b tx %b err %0d",
                     out_payload.field_kind, out_payload.item_index,
                     out_payload.byte_offset, out_payload.field_value,
                     out_payload.field_done, out_payload.tx_done,
                     out_payload.error_code);
          end
        end
      end
    end
  end

  // Abort a run that stops making progress
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    lim_items        = tsp_pkg::MAX_ITEM_COUNT_RST;
    lim_script       = tsp_pkg::MAX_SCRIPT_LENGTH_RST;
    prs_inputs_left  = '0;
    prs_outputs_left = '0;
    prs_item         = '0;
    prs_script_left  = '0;
    move_to(tsp_pkg::PH_IDLE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_tight_limits();
    test_wide_limits();
    test_mid_limits();
    test_backpressure();

    // Let any stray tag surface before the verdict
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && tag_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/tsp_pkg.sv
sv/transaction_stream_parser_unit.sv
sv/tsp_checker.sv
test/transaction_stream_parser_unit_tb.sv
